>>> rtl/debounced_button_blink_mode_controller_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the button debouncer and blink mode controller
// Shared helpers for the concurrent checks on the core's ports.
// ----------------------------------------------------------------------------
`ifndef DEBOUNCED_BUTTON_BLINK_MODE_CONTROLLER_CORE_MACROS_SVH
`define DEBOUNCED_BUTTON_BLINK_MODE_CONTROLLER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DBBMC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dbbmc check failed");

// The consequent must hold in the cycle after the antecedent.
`define DBBMC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dbbmc check failed");

`endif

>>> rtl/dbbmc_pkg.sv
// ----------------------------------------------------------------------------
// Button debouncer and blink mode controller package
// Payload types, mode and edge codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package dbbmc_pkg;

    typedef struct packed {
        logic        raw_level;
        logic [31:0] time_now;
    } sample_t;

    typedef struct packed {
        logic       led;
        logic [1:0] mode;
        logic [1:0] edge_kind;
        logic       toggled;
        logic [1:0] work_units;
    } result_t;

    localparam logic [1:0] BLINK_OFF  = 2'd0;
    localparam logic [1:0] BLINK_SLOW = 2'd1;
    localparam logic [1:0] BLINK_FAST = 2'd2;

    localparam logic [1:0] BTN_NO_EDGE  = 2'd0;
    localparam logic [1:0] BTN_PRESSED  = 2'd1;
    localparam logic [1:0] BTN_RELEASED = 2'd2;

    localparam logic [1:0] CFG_PRESS_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_SLOW_PERIOD     = 2'd1;
    localparam logic [1:0] CFG_FAST_PERIOD     = 2'd2;

    localparam logic [7:0]  RESET_PRESS_THRESHOLD = 8'd4;
    localparam logic [15:0] RESET_SLOW_PERIOD     = 16'd40;
    localparam logic [15:0] RESET_FAST_PERIOD     = 16'd10;

endpackage

>>> rtl/debounced_button_blink_mode_controller_core.sv
// ----------------------------------------------------------------------------
// Debounced button blink mode controller
// Integrating debouncer that cycles an LED between off, slow and fast blink.
// ----------------------------------------------------------------------------
// Usage:
//   sample channel: sample_valid / sample_stall carry one raw button level and
//   the current time. A transfer happens when valid is high and stall is low.
//   result channel: result_valid / result_stall carry the LED level, the mode,
//   the debounced edge, the toggle flag and the work count for each sample.
//   cfg channel: cfg_valid / cfg_ready write the press threshold (index 0),
//   the slow period (index 1) or the fast period (index 2); cfg_ready is
//   always high and other indexes are ignored. Write only while idle.
// Timing:
//   A sample is held in an input register, processed by one pass of compare
//   and add logic, and lands in the result register, from which it can
//   transfer to the receiver.
//   While the receiver does not stall, one sample per cycle is sustained; the
//   limit is the single update of the debounce and deadline state per cycle.
// Reset and stall:
//   Reset empties both registers, clears the debounce, mode, LED and deadline
//   state and loads the default register values. When the receiver stalls,
//   the result holds and the input register still accepts one more sample.
// ----------------------------------------------------------------------------
module debounced_button_blink_mode_controller_core #(
    parameter int TIME_WIDTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_stall,
    input  dbbmc_pkg::sample_t sample,
    output logic              result_valid,
    input  logic              result_stall,
    output dbbmc_pkg::result_t result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data
);
    import dbbmc_pkg::*;

    // Configuration registers.
    logic [7:0]  threshold_reg;
    logic [15:0] slow_period_reg;
    logic [15:0] fast_period_reg;

    // Debounce, mode and blink state.
    logic [7:0]            count_reg, count_next;
    logic                  stable_reg, stable_next;
    logic [1:0]            mode_reg, mode_next;
    logic                  led_reg, led_next;
    logic [TIME_WIDTH-1:0] due_reg, due_next;

    // Pipeline registers.
    logic    hold_valid_reg, hold_valid_next;
    sample_t hold_reg;
    logic    result_valid_reg, result_valid_next;
    result_t result_reg, result_next;

    logic sample_take;
    logic advance;

    logic [7:0]            count_step;
    logic                  press;
    logic                  release_seen;
    logic [1:0]            mode_cycled;
    logic [63:0]           now_wide;
    logic [63:0]           period_wide;
    logic [TIME_WIDTH-1:0] now;
    logic [TIME_WIDTH-1:0] period;
    logic                  led_armed;
    logic [TIME_WIDTH-1:0] due_armed;
    logic [TIME_WIDTH-1:0] lag;
    logic                  fire;

    assign cfg_ready    = 1'b1;
    assign advance      = hold_valid_reg && (!result_valid_reg || !result_stall);
    assign sample_stall = hold_valid_reg && !advance;
    assign sample_take  = sample_valid && !sample_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (sample_take)
        begin
            hold_valid_next = 1'b1;
        end
        else if (advance)
        begin
            hold_valid_next = 1'b0;
        end

        result_valid_next = result_valid_reg;
        if (advance)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    // Saturating integrator and edge detection.
    always_comb
    begin
        if (hold_reg.raw_level)
        begin
            count_step = (count_reg < threshold_reg) ? count_reg + 8'd1 : count_reg;
        end
        else
        begin
            count_step = (count_reg != 8'd0) ? count_reg - 8'd1 : count_reg;
        end
        press        = !stable_reg && (count_step == threshold_reg);
        release_seen = !press && stable_reg && (count_step == 8'd0);
    end

    always_comb
    begin
        case (mode_reg)
            BLINK_OFF:  mode_cycled = BLINK_SLOW;
            BLINK_SLOW: mode_cycled = BLINK_FAST;
            default:    mode_cycled = BLINK_OFF;
        endcase
    end

    // Deadline arming and the wrap-safe due test.
    always_comb
    begin
        mode_next   = press ? mode_cycled : mode_reg;
        now_wide    = {32'd0, hold_reg.time_now};
        now         = now_wide[TIME_WIDTH-1:0];
        period_wide = {48'd0, (mode_next == BLINK_FAST) ? fast_period_reg : slow_period_reg};
        period      = period_wide[TIME_WIDTH-1:0];

        led_armed = led_reg;
        due_armed = due_reg;
        if (press)
        begin
            led_armed = (mode_next != BLINK_OFF);
            if (mode_next != BLINK_OFF)
            begin
                due_armed = now + period;
            end
        end

        // The deadline is due when now minus due falls in the lower half range.
        lag  = now - due_armed;
        fire = (mode_next != BLINK_OFF) && !lag[TIME_WIDTH-1];

        led_next    = fire ? !led_armed : led_armed;
        due_next    = fire ? due_armed + period : due_armed;
        count_next  = count_step;
        stable_next = press ? 1'b1 : (release_seen ? 1'b0 : stable_reg);

        result_next.led        = led_next;
        result_next.mode       = mode_next;
        result_next.edge_kind  = press ? BTN_PRESSED : (release_seen ? BTN_RELEASED : BTN_NO_EDGE);
        result_next.toggled    = fire;
        result_next.work_units = 2'd1 + {1'b0, press} + {1'b0, fire};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg    <= RESET_PRESS_THRESHOLD;
            slow_period_reg  <= RESET_SLOW_PERIOD;
            fast_period_reg  <= RESET_FAST_PERIOD;
            count_reg        <= 8'd0;
            stable_reg       <= 1'b0;
            mode_reg         <= BLINK_OFF;
            led_reg          <= 1'b0;
            due_reg          <= '0;
            hold_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg   <= hold_valid_next;
            result_valid_reg <= result_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_PRESS_THRESHOLD: threshold_reg   <= cfg_data[7:0];
                    CFG_SLOW_PERIOD:     slow_period_reg <= cfg_data;
                    CFG_FAST_PERIOD:     fast_period_reg <= cfg_data;
                    default:             ;
                endcase
            end
            if (advance)
            begin
                count_reg  <= count_next;
                stable_reg <= stable_next;
                mode_reg   <= mode_next;
                led_reg    <= led_next;
                due_reg    <= due_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_take)
        begin
            hold_reg <= sample;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

endmodule

>>> rtl/dbbmc_checker.sv
// ----------------------------------------------------------------------------
// Port checker for the button debouncer and blink mode controller
// Watches the sample and result channels and the consistency of each result.
// ----------------------------------------------------------------------------
`include "debounced_button_blink_mode_controller_core_macros.svh"

module dbbmc_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               sample_valid,
    input logic               sample_stall,
    input dbbmc_pkg::sample_t sample,
    input logic               result_valid,
    input logic               result_stall,
    input dbbmc_pkg::result_t result
);
    import dbbmc_pkg::*;

    // A stalled result must stay offered and unchanged.
    `DBBMC_ASSERT_NEXT(a_result_hold, result_valid && result_stall,
        result_valid && $stable(result))

    // With the result register empty, the input side is never held off.
    `DBBMC_ASSERT_SAME(a_no_stall_when_empty, !result_valid, !sample_stall)

    // The work count is the sample plus a mode change plus a toggle.
    `DBBMC_ASSERT_SAME(a_work_count, result_valid,
        result.work_units == 2'd1 + {1'b0, result.edge_kind == BTN_PRESSED}
                                  + {1'b0, result.toggled})

    // In the off mode the LED is dark and never toggles.
    `DBBMC_ASSERT_SAME(a_off_is_dark, result_valid && (result.mode == BLINK_OFF),
        !result.led && !result.toggled)

endmodule

bind debounced_button_blink_mode_controller_core dbbmc_checker u_dbbmc_checker (.*);

>>> bench/dbbmc_blink_checker.sv
// ----------------------------------------------------------------------------
// Blink controller checker
// Watches the sample, result and register channels of the debounced button
// blink mode controller, predicts every result from its own copy of the
// debounce, mode, LED and deadline state, and compares each result transfer
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module dbbmc_blink_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               sample_valid,
    input  logic               sample_stall,
    input  dbbmc_pkg::sample_t sample,
    input  logic               result_valid,
    input  logic               result_stall,
    input  dbbmc_pkg::result_t result,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    output int                 fail_count,
    output int                 pending_results
);
    import dbbmc_pkg::*;

    localparam logic [31:0] HALF_RANGE = 32'h8000_0000;

    logic [7:0]  press_thr;
    logic [15:0] slow_ticks;
    logic [15:0] fast_ticks;

    logic [7:0]  integ_level;
    logic        button_held;
    logic [1:0]  mode_now;
    logic        led_now;
    logic [31:0] due_tick;

    result_t led_status_queue [$];

    initial fail_count = 0;

    task automatic report_mismatch(input string msg);
        $display("[%0t] blink check: %s", $time, msg);
        fail_count++;
    endtask

    function automatic logic [31:0] period_for(input logic [1:0] m);
        return {16'd0, (m == BLINK_FAST) ? fast_ticks : slow_ticks};
    endfunction

    // One debounce and blink step, updating the predicted state.
    task automatic step_blinker(input sample_t s, output result_t r);
        logic [1:0]  edge_seen;
        logic [1:0]  work;
        logic        fired;
        logic [31:0] lag;
        edge_seen = BTN_NO_EDGE;
        work = 2'd1;
        fired = 1'b0;

        if (s.raw_level)
        begin
            if (integ_level < press_thr)
                integ_level = integ_level + 8'd1;
        end
        else if (integ_level != 8'd0)
        begin
            integ_level = integ_level - 8'd1;
        end

        if (!button_held && integ_level == press_thr)
        begin
            button_held = 1'b1;
            edge_seen = BTN_PRESSED;
        end
        else if (button_held && integ_level == 8'd0)
        begin
            button_held = 1'b0;
            edge_seen = BTN_RELEASED;
        end

        if (edge_seen == BTN_PRESSED)
        begin
            work = work + 2'd1;
            case (mode_now)
                BLINK_OFF:  mode_now = BLINK_SLOW;
                BLINK_SLOW: mode_now = BLINK_FAST;
                default:    mode_now = BLINK_OFF;
            endcase
            if (mode_now == BLINK_OFF)
                led_now = 1'b0;
            else
            begin
                led_now = 1'b1;
                due_tick = s.time_now + period_for(mode_now);
            end
        end

        // The deadline is due when the time has reached it, modulo the wrap.
        if (mode_now != BLINK_OFF)
        begin
            lag = s.time_now - due_tick;
            if (lag < HALF_RANGE)
            begin
                work = work + 2'd1;
                fired = 1'b1;
                led_now = !led_now;
                due_tick = due_tick + period_for(mode_now);
            end
        end

        r.led = led_now;
        r.mode = mode_now;
        r.edge_kind = edge_seen;
        r.toggled = fired;
        r.work_units = work;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        result_t got;
        if (!rst_n)
        begin
            press_thr = RESET_PRESS_THRESHOLD;
            slow_ticks = RESET_SLOW_PERIOD;
            fast_ticks = RESET_FAST_PERIOD;
            integ_level = 8'd0;
            button_held = 1'b0;
            mode_now = BLINK_OFF;
            led_now = 1'b0;
            due_tick = 32'd0;
            led_status_queue.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_PRESS_THRESHOLD: press_thr = cfg_data[7:0];
                    CFG_SLOW_PERIOD:     slow_ticks = cfg_data;
                    CFG_FAST_PERIOD:     fast_ticks = cfg_data;
                    default:             ;  // Unused index, the write has no effect.
                endcase
            end

            if (result_valid && !result_stall)
            begin
                got = result;
                if (led_status_queue.size() == 0)
                    report_mismatch($sformatf("result transfer %p with none expected", got));
                else
                begin
                    want = led_status_queue.pop_front();
                    if (got.led !== want.led)
                        report_mismatch($sformatf("led %b, expected %b", got.led, want.led));
                    if (got.mode !== want.mode)
                        report_mismatch($sformatf("mode %0d, expected %0d",
                                                  got.mode, want.mode));
                    if (got.edge_kind !== want.edge_kind)
                        report_mismatch($sformatf("edge_kind %0d, expected %0d",
                                                  got.edge_kind, want.edge_kind));
                    if (got.toggled !== want.toggled)
                        report_mismatch($sformatf("toggled %b, expected %b",
                                                  got.toggled, want.toggled));
                    if (got.work_units !== want.work_units)
                        report_mismatch($sformatf("work_units %0d, expected %0d",
                                                  got.work_units, want.work_units));
                end
            end

            if (sample_valid && !sample_stall)
            begin
                step_blinker(sample, want);
                led_status_queue.push_back(want);
            end
        end
        pending_results = led_status_queue.size();
    end

endmodule

>>> bench/debounced_button_blink_mode_controller_core_tb.sv
// ----------------------------------------------------------------------------
// Debounced button blink mode controller testbench
// Drives button samples with a running time base through directed sequences
// and randomized press and release runs under several register settings and
// flow control patterns; the checker beside the core predicts and compares.
// ----------------------------------------------------------------------------
module debounced_button_blink_mode_controller_core_tb;
    import dbbmc_pkg::*;

    localparam logic [1:0] CFG_UNUSED = 2'd3;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        sample_valid = 1'b0;
    logic        sample_stall;
    sample_t     sample = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    result_t     result;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_PRESS_THRESHOLD;
    logic [15:0] cfg_data = 16'd0;

    int fail_count;
    int pending_results;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int cur_thr = int'(RESET_PRESS_THRESHOLD);

    debounced_button_blink_mode_controller_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    dbbmc_blink_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .sample_valid    (sample_valid),
        .sample_stall    (sample_stall),
        .sample          (sample),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .result          (result),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(negedge clk)
        result_stall <= rst_n && ($urandom_range(0, 99) < recv_stall_pct);

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic push_sample(input logic raw, input logic [31:0] t);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            sample_valid <= 1'b0;
            @(negedge clk);
        end
        sample_valid <= 1'b1;
        sample <= '{raw_level: raw, time_now: t};
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic settle();
        sample_valid <= 1'b0;
        while (pending_results != 0)
            @(negedge clk);
    endtask

    // Writes all three registers back to back, and the unused index if asked.
    task automatic program_settings(input logic [15:0] thr_word, input logic [15:0] slow,
                                    input logic [15:0] fast, input bit poke_unused);
        logic [1:0]  regs [4];
        logic [15:0] words [4];
        int          last;
        regs = '{CFG_PRESS_THRESHOLD, CFG_SLOW_PERIOD, CFG_FAST_PERIOD, CFG_UNUSED};
        words = '{thr_word, slow, fast, 16'($urandom)};
        last = poke_unused ? 3 : 2;
        for (int i = 0; i <= last; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[i];
            cfg_data <= words[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            @(negedge clk);
        end
        cfg_valid <= 1'b0;
        cur_thr = int'(thr_word[7:0]);
    endtask

    // Mostly clean runs of one level long enough to cross the threshold,
    // some with contact bounce, mixed with stretches of pure noise.
    task automatic run_phase(input int n_items);
        logic [31:0] tick;
        logic        level;
        logic        raw;
        int          left;
        int          run;
        int          bounce_pct;
        bit          noisy;
        tick = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 400)
                                           : $urandom;
        level = 1'($urandom_range(0, 1));
        left = n_items;
        while (left > 0)
        begin
            noisy = ($urandom_range(0, 99) < 20);
            if (noisy)
                run = $urandom_range(1, 12);
            else
            begin
                level = !level;
                run = $urandom_range(1, cur_thr + cur_thr / 2 + 2);
            end
            bounce_pct = ($urandom_range(0, 9) == 0) ? 8 : 0;
            while (run > 0 && left > 0)
            begin
                if (noisy)
                    raw = 1'($urandom_range(0, 1));
                else
                    raw = ($urandom_range(0, 99) < bounce_pct) ? !level : level;
                if ($urandom_range(0, 99) < 3)
                    tick = $urandom;
                else
                    tick = tick + $urandom_range(0, 6);
                push_sample(raw, tick);
                run--;
                left--;
            end
        end
        settle();
    endtask

    initial
    begin
        logic [31:0] tick;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: press into slow with a deadline that wraps past zero,
        // then release, press into fast, release and press back to off.
        tick = 32'hFFFF_FFF0;
        repeat (4)
        begin
            push_sample(1'b1, tick);
            tick++;
        end
        push_sample(1'b1, 32'hFFFF_FFFF);
        push_sample(1'b1, 32'h0000_0000);
        push_sample(1'b1, 32'h0000_001B);
        tick = 32'h0000_0020;
        repeat (4)
        begin
            push_sample(1'b0, tick);
            tick += 3;
        end
        repeat (4)
        begin
            push_sample(1'b1, tick);
            tick += 3;
        end
        repeat (4)
        begin
            push_sample(1'b0, tick);
            tick += 3;
        end
        repeat (4)
        begin
            push_sample(1'b1, tick);
            tick += 3;
        end
        repeat (4)
        begin
            push_sample(1'b0, tick);
            tick += 3;
        end
        settle();

        // Threshold lowered below the integrator level: no climb and no press
        // until the level has fallen to the new threshold.
        program_settings(16'd12, 16'd40, 16'd10, 1'b0);
        repeat (10)
        begin
            push_sample(1'b1, tick);
            tick += 2;
        end
        settle();
        program_settings(16'd3, 16'd40, 16'd10, 1'b0);
        repeat (2)
        begin
            push_sample(1'b1, tick);
            tick += 2;
        end
        repeat (7)
        begin
            push_sample(1'b0, tick);
            tick += 2;
        end
        settle();

        program_settings(16'd1, 16'd1, 16'hFFFF, 1'b0);
        run_phase(150);

        send_idle_pct = 72;
        program_settings(16'hFFFF, 16'hFFFF, 16'd1, 1'b0);
        run_phase(450);

        // Zero threshold and zero periods.
        send_idle_pct = 0;
        recv_stall_pct = 72;
        program_settings(16'h0000, 16'h0000, 16'h0000, 1'b0);
        run_phase(120);

        send_idle_pct = 7;
        recv_stall_pct = 7;
        program_settings(16'h5A03, 16'd7, 16'd2, 1'b1);
        run_phase(150);

        send_idle_pct = 0;
        recv_stall_pct = 0;
        program_settings(16'd8, 16'd25, 16'd5, 1'b1);
        run_phase(130);

        repeat (4) @(negedge clk);
        if (fail_count == 0 && pending_results == 0)
            $display("** debounced_button_blink_mode_controller_core: PASSED **");
        else
            $display("** debounced_button_blink_mode_controller_core: FAILED **");
        $finish;
    end

    initial
    begin
        #(12 * 600_000);
        $display("** debounced_button_blink_mode_controller_core: FAILED **");
        $finish;
    end

endmodule
